/* hdl/cardiac_pacing_stimulus_timer_top_defines.svh */
// ----------------------------------------------------------------------------
// Pacing stimulus timer assertion macros
// Concurrent check shorthands used by the top level.
// ----------------------------------------------------------------------------
`ifndef CARDIAC_PACING_STIMULUS_TIMER_TOP_DEFINES_SVH
`define CARDIAC_PACING_STIMULUS_TIMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PCST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcst check failed");

// next-cycle implication, disabled during reset
`define PCST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcst check failed");

`endif

/* hdl/pcst_pkg.sv */
// ----------------------------------------------------------------------------
// Pacing stimulus timer package
// Shared types, register indexes, mode codes, protocol constants and helpers.
// ----------------------------------------------------------------------------
package pcst_pkg;

    localparam int TICK_W = 32;

    localparam logic [2:0] REG_MODE            = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE       = 3'd1;
    localparam logic [2:0] REG_PULSE_DURATION  = 3'd2;
    localparam logic [2:0] REG_FIRST_START     = 3'd3;
    localparam logic [2:0] REG_BASE_INTERVAL   = 3'd4;
    localparam logic [2:0] REG_STIM_LIMIT      = 3'd5;
    localparam logic [2:0] REG_REPEAT_COUNT    = 3'd6;
    localparam logic [2:0] REG_EXTRA_INTERVALS = 3'd7;

    localparam logic [2:0] MODE_FIXED   = 3'd0;
    localparam logic [2:0] MODE_S2      = 3'd1;
    localparam logic [2:0] MODE_S3      = 3'd2;
    localparam logic [2:0] MODE_S4      = 3'd3;
    localparam logic [2:0] MODE_RESTIT  = 3'd4;
    localparam logic [2:0] MODE_DYNAMIC = 3'd5;

    localparam int REST_THR_HI_MS   = 100;
    localparam int REST_THR_MID_MS  = 30;
    localparam int REST_THR_LO_MS   = 20;
    localparam int REST_STEP_HI_MS  = 100;
    localparam int REST_STEP_MID_MS = 5;
    localparam int REST_STEP_LO_MS  = 1;
    localparam int REST_STEP_MIN_MS = 5;

    localparam int DYN_THR_HI_MS    = 1000;
    localparam int DYN_THR_MID_MS   = 300;
    localparam int DYN_THR_LO_MS    = 200;
    localparam int DYN_STEP_HI_MS   = 1000;
    localparam int DYN_STEP_MID_MS  = 50;
    localparam int DYN_STEP_LO_MS   = 10;
    localparam int DYN_STEP_MIN_MS  = 5;

    typedef struct packed {
        logic        [2:0]        mode;
        logic signed [15:0]       amplitude;
        logic        [15:0]       pulse_duration;
        logic signed [16:0]       stim_limit;
        logic        [7:0]        repeat_count;
        logic        [TICK_W-1:0] s1s2_ticks;
        logic        [TICK_W-1:0] s2s3_ticks;
        logic        [TICK_W-1:0] s3s4_ticks;
        logic        [TICK_W-1:0] min_s1s2_ticks;
    } cfg_t;

    typedef struct packed {
        logic [TICK_W-1:0] coupling;
        logic [TICK_W-1:0] next_decrease;
    } load_t;

    typedef struct packed {
        logic [TICK_W-1:0] next_start;
        logic [15:0]       count;
        logic [TICK_W-1:0] cycle_length;
        logic [TICK_W-1:0] coupling;
        logic [TICK_W-1:0] next_decrease;
    } state_t;

    typedef struct packed {
        logic signed [15:0] level;
        logic               active;
        logic        [15:0] count;
    } result_t;

    function automatic logic [TICK_W-1:0] ms16_ticks(input logic [15:0] ms,
                                                    input logic [TICK_W-1:0] tpm);
        return TICK_W'(TICK_W'(ms) * tpm);
    endfunction

    function automatic logic [TICK_W-1:0] ms32_ticks(input logic [TICK_W-1:0] ms,
                                                    input logic [TICK_W-1:0] tpm);
        logic [2*TICK_W-1:0] p;
        p = (2*TICK_W)'(ms) * (2*TICK_W)'(tpm);
        return (p[2*TICK_W-1:TICK_W] != '0) ? '1 : p[TICK_W-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                 input logic [TICK_W-1:0] b);
        logic [TICK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TICK_W] ? '1 : s[TICK_W-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] sat_sub(input logic [TICK_W-1:0] a,
                                                 input logic [TICK_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

/* hdl/pcst_cfg.sv */
// ----------------------------------------------------------------------------
// Pacing stimulus timer configuration registers
// Holds the register file and the tick values derived from millisecond fields.
// ----------------------------------------------------------------------------
module pcst_cfg #(
    parameter int TICKS_PER_MS = 100
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output pcst_pkg::cfg_t      cfg,
    output pcst_pkg::load_t     load
);

    localparam logic [pcst_pkg::TICK_W-1:0] TPM = pcst_pkg::TICK_W'(TICKS_PER_MS);

    pcst_pkg::cfg_t cfg_reg;

    always_comb
    begin
        load.coupling      = pcst_pkg::ms16_ticks(cfg_data[15:0], TPM);
        load.next_decrease = pcst_pkg::ms32_ticks(cfg_data[47:16], TPM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= '0;
            cfg_reg.amplitude      <= '0;
            cfg_reg.pulse_duration <= '0;
            cfg_reg.stim_limit     <= '1;
            cfg_reg.repeat_count   <= '0;
            cfg_reg.s1s2_ticks     <= '0;
            cfg_reg.s2s3_ticks     <= '0;
            cfg_reg.s3s4_ticks     <= '0;
            cfg_reg.min_s1s2_ticks <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcst_pkg::REG_MODE:
                begin
                    cfg_reg.mode <= cfg_data[2:0];
                end
                pcst_pkg::REG_AMPLITUDE:
                begin
                    cfg_reg.amplitude <= cfg_data[15:0];
                end
                pcst_pkg::REG_PULSE_DURATION:
                begin
                    cfg_reg.pulse_duration <= cfg_data[15:0];
                end
                pcst_pkg::REG_STIM_LIMIT:
                begin
                    cfg_reg.stim_limit <= cfg_data[16:0];
                end
                pcst_pkg::REG_REPEAT_COUNT:
                begin
                    cfg_reg.repeat_count <= cfg_data[7:0];
                end
                pcst_pkg::REG_EXTRA_INTERVALS:
                begin
                    cfg_reg.s1s2_ticks     <= pcst_pkg::ms16_ticks(cfg_data[15:0], TPM);
                    cfg_reg.s2s3_ticks     <= pcst_pkg::ms16_ticks(cfg_data[31:16], TPM);
                    cfg_reg.s3s4_ticks     <= pcst_pkg::ms16_ticks(cfg_data[47:32], TPM);
                    cfg_reg.min_s1s2_ticks <= pcst_pkg::ms16_ticks(cfg_data[63:48], TPM);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/pcst_step.sv */
// ----------------------------------------------------------------------------
// Pacing stimulus timer step logic
// Evaluates the pulse window for one time sample and the next schedule state.
// ----------------------------------------------------------------------------
module pcst_step #(
    parameter int TICKS_PER_MS = 100,
    parameter int TIME_STEP    = 1
) (
    input  logic [pcst_pkg::TICK_W-1:0] time_now,
    input  pcst_pkg::cfg_t              cfg,
    input  pcst_pkg::state_t            st,
    input  logic signed [50:0]          lim_prod,
    input  logic signed [50:0]          lim_m1_prod,
    output pcst_pkg::state_t            st_next,
    output pcst_pkg::result_t           res
);

    localparam int TW = pcst_pkg::TICK_W;

    localparam logic [TW-1:0] R_THR_HI   = TW'(pcst_pkg::REST_THR_HI_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] R_THR_MID  = TW'(pcst_pkg::REST_THR_MID_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] R_THR_LO   = TW'(pcst_pkg::REST_THR_LO_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] R_STEP_HI  = TW'(pcst_pkg::REST_STEP_HI_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] R_STEP_MID = TW'(pcst_pkg::REST_STEP_MID_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] R_STEP_LO  = TW'(pcst_pkg::REST_STEP_LO_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] R_STEP_MIN = TW'(pcst_pkg::REST_STEP_MIN_MS * TICKS_PER_MS);

    localparam logic [TW-1:0] D_THR_HI   = TW'(pcst_pkg::DYN_THR_HI_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] D_THR_MID  = TW'(pcst_pkg::DYN_THR_MID_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] D_THR_LO   = TW'(pcst_pkg::DYN_THR_LO_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] D_STEP_HI  = TW'(pcst_pkg::DYN_STEP_HI_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] D_STEP_MID = TW'(pcst_pkg::DYN_STEP_MID_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] D_STEP_LO  = TW'(pcst_pkg::DYN_STEP_LO_MS * TICKS_PER_MS);
    localparam logic [TW-1:0] D_STEP_MIN = TW'(pcst_pkg::DYN_STEP_MIN_MS * TICKS_PER_MS);

    logic [TW:0]        t_ext;
    logic [TW:0]        win_end;
    logic               in_window;
    logic               pulse_end;
    logic               active;
    logic [15:0]        cnt_inc;
    logic               lim_open;
    logic [16:0]        cnt17;
    logic [16:0]        rep17;
    logic [16:0]        rep_p1;
    logic [16:0]        inc17;
    logic signed [50:0] t_s;
    logic [TW-1:0]      coup_dec;
    logic [TW-1:0]      cyc_dec;
    logic [TW+5:0]      dec_sum;

    always_comb
    begin
        t_ext     = {1'b0, time_now};
        win_end   = {1'b0, st.next_start} + (TW+1)'(cfg.pulse_duration);
        in_window = (time_now >= st.next_start) && (t_ext <= win_end);
        pulse_end = in_window && ((t_ext + (TW+1)'(TIME_STEP)) >= win_end);
        cnt_inc   = (st.count != '1) ? (st.count + 16'd1) : st.count;
        cnt17     = {1'b0, st.count};
        inc17     = {1'b0, cnt_inc};
        rep17     = {9'd0, cfg.repeat_count};
        rep_p1    = rep17 + 17'd1;
        lim_open  = ($signed({2'b00, st.count}) < $signed({cfg.stim_limit[16], cfg.stim_limit}))
                    || (cfg.stim_limit == '1);
        t_s       = $signed({19'd0, time_now});

        if (st.coupling > R_THR_HI)
        begin
            coup_dec = pcst_pkg::sat_sub(st.coupling, R_STEP_HI);
        end
        else if (st.coupling > R_THR_MID)
        begin
            coup_dec = pcst_pkg::sat_sub(st.coupling, R_STEP_MID);
        end
        else if (st.coupling > R_THR_LO)
        begin
            coup_dec = pcst_pkg::sat_sub(st.coupling, R_STEP_LO);
        end
        else
        begin
            coup_dec = pcst_pkg::sat_sub(st.coupling, R_STEP_MIN);
        end

        if (st.cycle_length > D_THR_HI)
        begin
            cyc_dec = pcst_pkg::sat_sub(st.cycle_length, D_STEP_HI);
        end
        else if (st.cycle_length > D_THR_MID)
        begin
            cyc_dec = pcst_pkg::sat_sub(st.cycle_length, D_STEP_MID);
        end
        else if (st.cycle_length > D_THR_LO)
        begin
            cyc_dec = pcst_pkg::sat_sub(st.cycle_length, D_STEP_LO);
        end
        else
        begin
            cyc_dec = pcst_pkg::sat_sub(st.cycle_length, D_STEP_MIN);
        end

        // hold factor of twenty times the new cycle length: 16c + 4c
        dec_sum = (TW+6)'(st.next_decrease) + ((TW+6)'(cyc_dec) << 4)
                  + ((TW+6)'(cyc_dec) << 2);

        st_next = st;
        active  = 1'b0;

        case (cfg.mode)
            pcst_pkg::MODE_S2, pcst_pkg::MODE_S3, pcst_pkg::MODE_S4:
            begin
                if (lim_open)
                begin
                    active = in_window;
                    if (pulse_end)
                    begin
                        if (cnt17 < rep17)
                        begin
                            st_next.next_start = pcst_pkg::sat_add(st.next_start,
                                                                   st.cycle_length);
                            st_next.count      = cnt_inc;
                        end
                        else if (cfg.mode == pcst_pkg::MODE_S2)
                        begin
                            st_next.next_start = pcst_pkg::sat_add(st.next_start, st.coupling);
                            st_next.count      = '0;
                        end
                        else if (cnt17 == rep17)
                        begin
                            st_next.next_start = pcst_pkg::sat_add(st.next_start, st.coupling);
                            st_next.count      = cnt_inc;
                        end
                        else if ((cfg.mode == pcst_pkg::MODE_S4) && (cnt17 == rep_p1))
                        begin
                            st_next.next_start = pcst_pkg::sat_add(st.next_start,
                                                                   cfg.s2s3_ticks);
                            st_next.count      = cnt_inc;
                        end
                        else
                        begin
                            st_next.next_start = pcst_pkg::sat_add(st.next_start,
                                (cfg.mode == pcst_pkg::MODE_S3) ? cfg.s2s3_ticks
                                                                : cfg.s3s4_ticks);
                            st_next.count      = '0;
                        end
                    end
                end
            end
            pcst_pkg::MODE_RESTIT:
            begin
                if (t_s < lim_prod)
                begin
                    active = in_window;
                    if (pulse_end)
                    begin
                        st_next.next_start = pcst_pkg::sat_add(st.next_start, st.cycle_length);
                        st_next.count      = (t_s > lim_m1_prod) ? '0 : cnt_inc;
                    end
                end
                else if (st.coupling >= cfg.min_s1s2_ticks)
                begin
                    active = in_window;
                    if (pulse_end)
                    begin
                        st_next.count = cnt_inc;
                        if (inc17 < rep17)
                        begin
                            st_next.next_start = pcst_pkg::sat_add(st.next_start,
                                                                   st.cycle_length);
                        end
                        else if (inc17 == rep17)
                        begin
                            st_next.next_start = pcst_pkg::sat_add(st.next_start, st.coupling);
                        end
                        else if (inc17 == rep_p1)
                        begin
                            st_next.next_start = pcst_pkg::sat_add(st.next_start,
                                                                   st.cycle_length);
                            st_next.count      = '0;
                            st_next.coupling   = coup_dec;
                        end
                    end
                end
            end
            pcst_pkg::MODE_DYNAMIC:
            begin
                if (st.cycle_length >= cfg.s1s2_ticks)
                begin
                    active = in_window;
                    if (pulse_end)
                    begin
                        st_next.count      = cnt_inc;
                        st_next.next_start = pcst_pkg::sat_add(st.next_start, st.cycle_length);
                    end
                    if (time_now > st.next_decrease)
                    begin
                        st_next.cycle_length  = cyc_dec;
                        st_next.next_decrease = (dec_sum[TW+5:TW] != '0) ? '1
                                                                        : dec_sum[TW-1:0];
                    end
                end
            end
            default:
            begin
                if (lim_open)
                begin
                    active = in_window;
                    if (pulse_end)
                    begin
                        st_next.count      = cnt_inc;
                        st_next.next_start = pcst_pkg::sat_add(st.next_start, st.cycle_length);
                    end
                end
            end
        endcase

        res.level  = active ? cfg.amplitude : 16'sd0;
        res.active = active;
        res.count  = st_next.count;
    end

endmodule

/* hdl/cardiac_pacing_stimulus_timer_top.sv */
// ----------------------------------------------------------------------------
// Cardiac pacing stimulus timer
// The accepted request loads the input register, which feeds the result register.
// One request per cycle unless the output stalls; the schedule state is registered.
// Reset clears schedule state and loads register defaults (limit unlimited).
// ----------------------------------------------------------------------------
`include "cardiac_pacing_stimulus_timer_top_defines.svh"

module cardiac_pacing_stimulus_timer_top #(
    parameter int TICKS_PER_MS = 100,
    parameter int TIME_STEP    = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        time_now,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] stimulus_level,
    output logic               pulse_active,
    output logic [15:0]        stimuli_counted
);

    pcst_pkg::cfg_t     cfg;
    pcst_pkg::load_t    load;
    pcst_pkg::state_t   st_reg;
    pcst_pkg::state_t   st_next;
    pcst_pkg::result_t  res;

    logic               t_valid_reg;
    logic [31:0]        t_reg;
    logic               out_valid_reg;
    logic signed [15:0] level_reg;
    logic               active_reg;
    logic [15:0]        count_reg;
    logic               advance;

    logic signed [17:0] lim18;
    logic signed [17:0] lim_m1;
    logic signed [32:0] cyc33;
    logic signed [50:0] lim_prod_next;
    logic signed [50:0] lim_m1_prod_next;
    logic signed [50:0] lim_prod_reg;
    logic signed [50:0] lim_m1_prod_reg;

    pcst_cfg #(
        .TICKS_PER_MS(TICKS_PER_MS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg),
        .load     (load)
    );

    pcst_step #(
        .TICKS_PER_MS(TICKS_PER_MS),
        .TIME_STEP   (TIME_STEP)
    ) u_step (
        .time_now   (t_reg),
        .cfg        (cfg),
        .st         (st_reg),
        .lim_prod   (lim_prod_reg),
        .lim_m1_prod(lim_m1_prod_reg),
        .st_next    (st_next),
        .res        (res)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !t_valid_reg || advance;

    always_comb
    begin
        lim18            = {cfg.stim_limit[16], cfg.stim_limit};
        lim_m1           = lim18 - 18'sd1;
        cyc33            = $signed({1'b0, st_reg.cycle_length});
        lim_prod_next    = lim18 * cyc33;
        lim_m1_prod_next = lim_m1 * cyc33;
    end

    always_ff @(posedge clk)
    begin
        lim_prod_reg    <= lim_prod_next;
        lim_m1_prod_reg <= lim_m1_prod_next;
        if (in_valid && in_ready)
        begin
            t_reg <= time_now;
        end
        if (t_valid_reg && advance)
        begin
            level_reg  <= res.level;
            active_reg <= res.active;
            count_reg  <= res.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                t_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                t_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= t_valid_reg;
            end

            if (t_valid_reg && advance)
            begin
                st_reg <= st_next;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    pcst_pkg::REG_FIRST_START:
                    begin
                        st_reg.next_start <= cfg_data[31:0];
                    end
                    pcst_pkg::REG_BASE_INTERVAL:
                    begin
                        st_reg.cycle_length <= cfg_data[31:0];
                    end
                    pcst_pkg::REG_EXTRA_INTERVALS:
                    begin
                        st_reg.coupling      <= load.coupling;
                        st_reg.next_decrease <= load.next_decrease;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign stimulus_level  = level_reg;
    assign pulse_active    = active_reg;
    assign stimuli_counted = count_reg;

    `PCST_ASSERT_NOW(a_in_stall_cause, clk, rst_n, !in_ready, t_valid_reg && out_valid_reg && !out_ready)
    `PCST_ASSERT_NEXT(a_stalled_request_held, clk, rst_n, t_valid_reg && !advance, t_valid_reg && $stable(t_reg))
    `PCST_ASSERT_NOW(a_result_has_source, clk, rst_n, $rose(out_valid_reg), $past(t_valid_reg))

endmodule

/* bench/stimulus_timer_monitor.sv */
// ----------------------------------------------------------------------------
// Pacing stimulus timer monitor
// Watches the register port and the request and result channels of the timer,
// keeps its own copy of the pacing schedule, predicts the level, activity and
// stimulus count for every accepted time sample and compares each returned
// result with the oldest prediction. Hands the failure count and the number
// of outstanding predictions to the bench top.
// ----------------------------------------------------------------------------
module stimulus_timer_monitor #(
    parameter int TICKS_PER_MS = 100,
    parameter int TIME_STEP    = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [31:0]        time_now,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] stimulus_level,
    input  logic               pulse_active,
    input  logic [15:0]        stimuli_counted,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]  mode_r;
    logic [15:0] amplitude_r;
    logic [15:0] width_r;
    logic [16:0] limit_r;
    logic [7:0]  repeat_r;
    logic [63:0] extra_r;

    logic [31:0] start_q;
    logic [31:0] cycle_q;
    logic [31:0] coupling_q;
    logic [31:0] decrease_q;
    logic [15:0] count_q;

    pcst_pkg::result_t expected_pulses[$];
    pcst_pkg::result_t head_pulse;
    pcst_pkg::result_t seen_pulse;
    int                errors = 0;

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {33'd0, a} + {1'b0, b};
        return (s > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    function automatic logic [31:0] ms_to_ticks(input logic [31:0] ms);
        logic [63:0] p;
        p = {32'd0, ms} * 64'(TICKS_PER_MS);
        return (p > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic logic [31:0] extra_ticks(input int lo, input int span);
        logic [63:0] f;
        f = extra_r >> lo;
        f = (span == 16) ? (f & 64'h0000_0000_0000_FFFF) : (f & 64'h0000_0000_FFFF_FFFF);
        return ms_to_ticks(f[31:0]);
    endfunction

    function automatic void bump_count();
        if (count_q != 16'hFFFF)
            count_q = count_q + 16'd1;
    endfunction

    function automatic pcst_pkg::result_t advance_pacing(input logic [31:0] t);
        logic [63:0]       s;
        logic [63:0]       e;
        logic [63:0]       tt;
        logic              in_window;
        logic              closing;
        logic              act;
        longint            lim;
        longint            cnt;
        longint            cyc;
        longint            tnow;
        logic [31:0]       c;
        pcst_pkg::result_t r;
        s         = {32'd0, start_q};
        e         = s + {48'd0, width_r};
        tt        = {32'd0, t};
        in_window = (tt >= s) && (tt <= e);
        closing   = in_window && (tt + 64'(TIME_STEP) >= e);
        act       = 1'b0;
        lim       = longint'($signed(limit_r));
        cnt       = longint'({48'd0, count_q});
        cyc       = longint'({32'd0, cycle_q});
        tnow      = longint'(tt);

        if (mode_r == pcst_pkg::MODE_S2 || mode_r == pcst_pkg::MODE_S3
            || mode_r == pcst_pkg::MODE_S4)
        begin
            if (cnt < lim || lim == -1)
            begin
                act = in_window;
                if (closing)
                begin
                    if (count_q < {8'd0, repeat_r})
                    begin
                        start_q = clamp_add(start_q, {32'd0, cycle_q});
                        bump_count();
                    end
                    else if (mode_r == pcst_pkg::MODE_S2)
                    begin
                        start_q = clamp_add(start_q, {32'd0, coupling_q});
                        count_q = '0;
                    end
                    else if (count_q == {8'd0, repeat_r})
                    begin
                        start_q = clamp_add(start_q, {32'd0, coupling_q});
                        bump_count();
                    end
                    else if (mode_r == pcst_pkg::MODE_S4 &&
                             32'(count_q) == 32'(repeat_r) + 32'd1)
                    begin
                        start_q = clamp_add(start_q, {32'd0, extra_ticks(16, 16)});
                        bump_count();
                    end
                    else
                    begin
                        start_q = clamp_add(start_q, {32'd0,
                            extra_ticks((mode_r == pcst_pkg::MODE_S3) ? 16 : 32, 16)});
                        count_q = '0;
                    end
                end
            end
        end
        else if (mode_r == pcst_pkg::MODE_RESTIT)
        begin
            if (tnow < lim * cyc)
            begin
                act = in_window;
                if (closing)
                begin
                    start_q = clamp_add(start_q, {32'd0, cycle_q});
                    if (tnow > (lim - 1) * cyc)
                        count_q = '0;
                    else
                        bump_count();
                end
            end
            else if (coupling_q >= extra_ticks(48, 16))
            begin
                act = in_window;
                if (closing)
                begin
                    bump_count();
                    if (count_q < {8'd0, repeat_r})
                    begin
                        start_q = clamp_add(start_q, {32'd0, cycle_q});
                    end
                    else if (count_q == {8'd0, repeat_r})
                    begin
                        start_q = clamp_add(start_q, {32'd0, coupling_q});
                    end
                    else if (32'(count_q) == 32'(repeat_r) + 32'd1)
                    begin
                        c       = coupling_q;
                        start_q = clamp_add(start_q, {32'd0, cycle_q});
                        count_q = '0;
                        if (c > 32'(pcst_pkg::REST_THR_HI_MS * TICKS_PER_MS))
                            coupling_q = floor_sub(c,
                                32'(pcst_pkg::REST_STEP_HI_MS * TICKS_PER_MS));
                        else if (c > 32'(pcst_pkg::REST_THR_MID_MS * TICKS_PER_MS))
                            coupling_q = floor_sub(c,
                                32'(pcst_pkg::REST_STEP_MID_MS * TICKS_PER_MS));
                        else if (c > 32'(pcst_pkg::REST_THR_LO_MS * TICKS_PER_MS))
                            coupling_q = floor_sub(c,
                                32'(pcst_pkg::REST_STEP_LO_MS * TICKS_PER_MS));
                        else
                            coupling_q = floor_sub(c,
                                32'(pcst_pkg::REST_STEP_MIN_MS * TICKS_PER_MS));
                    end
                end
            end
        end
        else if (mode_r == pcst_pkg::MODE_DYNAMIC)
        begin
            if (cycle_q >= extra_ticks(0, 16))
            begin
                act = in_window;
                if (closing)
                begin
                    bump_count();
                    start_q = clamp_add(start_q, {32'd0, cycle_q});
                end
                if (t > decrease_q)
                begin
                    c = cycle_q;
                    if (c > 32'(pcst_pkg::DYN_THR_HI_MS * TICKS_PER_MS))
                        c = floor_sub(c, 32'(pcst_pkg::DYN_STEP_HI_MS * TICKS_PER_MS));
                    else if (c > 32'(pcst_pkg::DYN_THR_MID_MS * TICKS_PER_MS))
                        c = floor_sub(c, 32'(pcst_pkg::DYN_STEP_MID_MS * TICKS_PER_MS));
                    else if (c > 32'(pcst_pkg::DYN_THR_LO_MS * TICKS_PER_MS))
                        c = floor_sub(c, 32'(pcst_pkg::DYN_STEP_LO_MS * TICKS_PER_MS));
                    else
                        c = floor_sub(c, 32'(pcst_pkg::DYN_STEP_MIN_MS * TICKS_PER_MS));
                    cycle_q    = c;
                    decrease_q = clamp_add(decrease_q, {32'd0, c} * 64'd20);
                end
            end
        end
        else
        begin
            if (cnt < lim || lim == -1)
            begin
                act = in_window;
                if (closing)
                begin
                    bump_count();
                    start_q = clamp_add(start_q, {32'd0, cycle_q});
                end
            end
        end

        r.level  = act ? amplitude_r : 16'd0;
        r.active = act;
        r.count  = count_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_r      = pcst_pkg::MODE_FIXED;
            amplitude_r = '0;
            width_r     = '0;
            limit_r     = '1;
            repeat_r    = '0;
            extra_r     = '0;
            start_q     = '0;
            cycle_q     = '0;
            coupling_q  = '0;
            decrease_q  = '0;
            count_q     = '0;
            expected_pulses.delete();
            pending    <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pcst_pkg::REG_MODE:           mode_r      = cfg_data[2:0];
                    pcst_pkg::REG_AMPLITUDE:      amplitude_r = cfg_data[15:0];
                    pcst_pkg::REG_PULSE_DURATION: width_r     = cfg_data[15:0];
                    pcst_pkg::REG_FIRST_START:    start_q     = cfg_data[31:0];
                    pcst_pkg::REG_BASE_INTERVAL:  cycle_q     = cfg_data[31:0];
                    pcst_pkg::REG_STIM_LIMIT:     limit_r     = cfg_data[16:0];
                    pcst_pkg::REG_REPEAT_COUNT:   repeat_r    = cfg_data[7:0];
                    pcst_pkg::REG_EXTRA_INTERVALS:
                    begin
                        extra_r    = cfg_data;
                        coupling_q = extra_ticks(0, 16);
                        decrease_q = extra_ticks(16, 32);
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_valid && in_ready)
                expected_pulses.push_back(advance_pacing(time_now));

            if (out_valid && out_ready)
            begin
                seen_pulse.level  = stimulus_level;
                seen_pulse.active = pulse_active;
                seen_pulse.count  = stimuli_counted;
                if (expected_pulses.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result with no request pending: %s %0d %0b %0d",
                                 $time, "level/active/count", $signed(seen_pulse.level),
                                 seen_pulse.active, seen_pulse.count);
                    errors++;
                end
                else
                begin
                    head_pulse = expected_pulses.pop_front();
                    if (seen_pulse !== head_pulse)
                    begin
                        if (errors < 10)
                            $display({"%0t: mismatch: expected level %0d active %0b ",
                                      "count %0d, got level %0d active %0b count %0d"},
                                     $time, $signed(head_pulse.level), head_pulse.active,
                                     head_pulse.count, $signed(seen_pulse.level),
                                     seen_pulse.active, seen_pulse.count);
                        errors++;
                    end
                end
            end

            pending    <= expected_pulses.size();
            fail_count <= errors;
        end
    end

endmodule

/* bench/tb_cardiac_pacing_stimulus_timer_top.sv */
// ----------------------------------------------------------------------------
// Pacing stimulus timer bench
// Programs the timer through its register port, feeds runs of time samples
// with random gaps, noise samples and receiver stalls, including one long
// receiver hold-off, and judges by the monitor's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_cardiac_pacing_stimulus_timer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TIME_STEP    = 1;
    localparam int          ITEM_GOAL    = 1575;
    localparam logic [2:0]  MODE_SPARE_A = 3'd6;
    localparam logic [2:0]  MODE_SPARE_B = 3'd7;
    localparam logic [16:0] LIMIT_NONE   = 17'h1FFFF;

    typedef struct {
        logic [2:0]  mode;
        logic [15:0] amplitude;
        logic [15:0] pulse_width;
        logic [31:0] first_start;
        logic [31:0] base_interval;
        logic [16:0] limit;
        logic [7:0]  repeats;
        logic [63:0] extra;
    } pace_setup_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [31:0]        time_now  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] stimulus_level;
    logic               pulse_active;
    logic [15:0]        stimuli_counted;

    int   fail_count;
    int   pending;
    int   sent_total = 0;
    logic gappy      = 1'b1;
    logic calm       = 1'b0;
    logic long_hold  = 1'b0;

    cardiac_pacing_stimulus_timer_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .time_now        (time_now),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stimulus_level  (stimulus_level),
        .pulse_active    (pulse_active),
        .stimuli_counted (stimuli_counted)
    );

    stimulus_timer_monitor timer_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .time_now        (time_now),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stimulus_level  (stimulus_level),
        .pulse_active    (pulse_active),
        .stimuli_counted (stimuli_counted),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic load_setup(input pace_setup_t p);
        logic [63:0] word [8];
        int          k;
        word[pcst_pkg::REG_MODE]            = 64'(p.mode);
        word[pcst_pkg::REG_AMPLITUDE]       = 64'(p.amplitude);
        word[pcst_pkg::REG_PULSE_DURATION]  = 64'(p.pulse_width);
        word[pcst_pkg::REG_FIRST_START]     = 64'(p.first_start);
        word[pcst_pkg::REG_BASE_INTERVAL]   = 64'(p.base_interval);
        word[pcst_pkg::REG_STIM_LIMIT]      = 64'(p.limit);
        word[pcst_pkg::REG_REPEAT_COUNT]    = 64'(p.repeats);
        word[pcst_pkg::REG_EXTRA_INTERVALS] = p.extra;
        for (k = 0; k < 8; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(k);
            cfg_data  <= word[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic offer_times(input logic [31:0] t0, input int count, input int noise_pct);
        logic [31:0] t;
        int          k;
        t = t0;
        for (k = 0; k < count; k++)
        begin
            if (gappy && !calm && $urandom_range(0, 99) < 20)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            in_valid <= 1'b1;
            if ($urandom_range(0, 99) < noise_pct)
                time_now <= $urandom;
            else
            begin
                time_now <= t;
                t = t + TIME_STEP;
            end
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            sent_total++;
        end
        in_valid <= 1'b0;
    endtask

    task automatic settle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: random ready bursts, held low during the long hold-off, high while calm
    initial
    begin
        int left;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
                out_ready <= 1'b0;
            else if (calm)
                out_ready <= 1'b1;
            else if (left > 0)
                left--;
            else
            begin
                int r;
                r = $urandom_range(0, 9);
                if (r < 3)
                begin
                    out_ready <= 1'b0;
                    left = $urandom_range(1, 12) - 1;
                end
                else
                begin
                    out_ready <= 1'b1;
                    left = $urandom_range(1, (r == 9) ? 80 : 15) - 1;
                end
            end
        end
    end

    // hold off the receiver long enough to back up the input
    initial
    begin
        wait (sent_total >= 400);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        pace_setup_t p;
        logic [31:0] t0;
        int          k;
        int          r;
        int          n;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // reset defaults, time at both ends of its range
        offer_times(32'hFFFF_FFFF, 2, 0);
        settle();

        for (k = 0; k < 9; k++)
        begin
            p.mode          = pcst_pkg::MODE_FIXED;
            p.amplitude     = 16'h7FFF;
            p.pulse_width   = '0;
            p.first_start   = '0;
            p.base_interval = 32'd1;
            p.limit         = LIMIT_NONE;
            p.repeats       = '0;
            p.extra         = '0;
            t0              = '0;
            case (k)
                0:
                begin
                    p.pulse_width   = 16'd1;
                    p.first_start   = 32'hFFFF_FFFE;
                    p.base_interval = 32'hFFFF_FFFF;
                    p.repeats       = 8'hFF;
                    p.extra         = '1;
                    t0              = 32'hFFFF_FFFD;
                end
                1:
                begin
                    p.mode          = pcst_pkg::MODE_S2;
                    p.amplitude     = 16'h8000;
                    p.base_interval = '0;
                    p.limit         = 17'h0FFFF;
                end
                2:
                begin
                    p.mode          = pcst_pkg::MODE_S3;
                    p.amplitude     = 16'd1;
                    p.pulse_width   = 16'd1;
                    p.first_start   = 32'd5;
                    p.base_interval = 32'd2;
                    p.limit         = 17'h1FFFE;
                    p.repeats       = 8'd1;
                    p.extra         = {4{16'd1}};
                    t0              = 32'd4;
                end
                3:
                begin
                    p.mode        = pcst_pkg::MODE_S4;
                    p.amplitude   = 16'hFFFF;
                    p.pulse_width = 16'hFFFF;
                    p.first_start = 32'd10;
                    p.extra       = {4{16'd1}};
                    t0            = 32'd10;
                end
                4:
                begin
                    p.mode        = pcst_pkg::MODE_RESTIT;
                    p.amplitude   = 16'd100;
                    p.first_start = 32'd3;
                    p.limit       = 17'h1FFFE;
                    t0            = 32'd3;
                end
                5:
                begin
                    p.mode          = pcst_pkg::MODE_RESTIT;
                    p.pulse_width   = 16'd2;
                    p.base_interval = 32'hFFFF_FFFF;
                    p.limit         = 17'h0FFFF;
                end
                6:
                begin
                    p.mode          = pcst_pkg::MODE_DYNAMIC;
                    p.pulse_width   = 16'd2;
                    p.base_interval = 32'd110000;
                end
                7: p.mode = MODE_SPARE_A;
                default:
                begin
                    p.mode  = MODE_SPARE_B;
                    p.limit = '0;
                end
            endcase
            load_setup(p);
            offer_times(t0, 3, 0);
            settle();
        end

        while (sent_total < ITEM_GOAL)
        begin
            if (sent_total > ITEM_GOAL - 250)
                calm <= 1'b1;
            r = $urandom_range(0, 9);
            if (r < 4)
                t0 = $urandom_range(0, 300);
            else if (r < 8)
                t0 = $urandom;
            else
                t0 = 32'hFFFF_FFFF - $urandom_range(0, 400);

            if ($urandom_range(0, 99) < 15)
            begin
                p.mode          = 3'($urandom);
                p.amplitude     = 16'($urandom);
                p.pulse_width   = 16'($urandom);
                p.first_start   = $urandom;
                p.base_interval = $urandom;
                p.limit         = 17'($urandom);
                p.repeats       = 8'($urandom);
                p.extra         = {$urandom, $urandom};
            end
            else
            begin
                p.mode          = 3'($urandom_range(0, 7));
                p.amplitude     = 16'($urandom);
                p.pulse_width   = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                              : 16'($urandom_range(0, 6));
                p.first_start   = t0 + $urandom_range(0, 20);
                p.base_interval = ($urandom_range(0, 9) == 0) ? $urandom
                                                              : $urandom_range(0, 40);
                p.limit         = $urandom_range(0, 1) ? LIMIT_NONE
                                                       : 17'($urandom_range(0, 12));
                p.repeats       = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                               : 8'($urandom_range(0, 4));
                p.extra         = {16'($urandom_range(0, 1)), 16'($urandom_range(1, 2)),
                                   16'($urandom_range(1, 2)), 16'($urandom_range(1, 2))};
                if (p.mode == pcst_pkg::MODE_DYNAMIC)
                begin
                    r = $urandom_range(0, 2);
                    if (r == 0)
                        p.base_interval = $urandom_range(0, 40);
                    else if (r == 1)
                        p.base_interval = $urandom_range(20000, 30000);
                    else
                        p.base_interval = $urandom_range(100000, 120000);
                    p.extra = {16'd0, 32'(t0 / 100 + $urandom_range(0, 2)),
                               16'($urandom_range(0, 1))};
                end
            end

            n = $urandom_range(60, 300);
            if (n > ITEM_GOAL - sent_total)
                n = ITEM_GOAL - sent_total;
            load_setup(p);
            gappy <= ($urandom_range(0, 9) < 7);
            offer_times(t0, n, ($urandom_range(0, 4) == 0) ? 0 : 5);
            settle();
        end

        repeat (6) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
